// ----- sv/sfq_pkg.sv -----
package sfq_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CMP
    } t_state;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

endpackage

// ----- sv/searchable_fifo_queue_top.sv -----
// Searchable queue of signed 32-bit words, held in a ring of DEPTH entries.
// A request is taken at a rising edge where start is high and busy is low.
// i_kind selects push of i_value, pop of the oldest entry, or a search for
// i_value from oldest to newest; the unused code does nothing.
// Each request yields exactly one result on o_status, o_position and o_length,
// valid for the single cycle in which o_done is high.
// Push, pop and the unused code report in the cycle after the request is taken,
// as does a search of an empty queue.
// A search reads one entry per cycle through the single read port of the
// entry memory and tests it with one shared comparator; a match at position p,
// counted from 1 at the oldest entry, reports that position, and a miss reports
// once every held entry has been tested, so a search never scans past them.
// busy stays high until the result is shown, and a new request may be taken
// in the cycle where o_done is high.
// The receiver cannot stall, so every result must be captured when shown.
// Reset empties the queue and returns the sequencer to idle; the entry
// memory is not cleared, since only held entries are ever read.
module searchable_fifo_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_value,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [4:0]         o_position,
    output logic [4:0]         o_length
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    function automatic logic [4:0] low5(input logic [CW-1:0] v);
        logic [CW+4:0] ext;
        ext = {5'b0, v};
        return ext[4:0];
    endfunction

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    sfq_pkg::t_state r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_ridx, n_ridx;
    logic [CW-1:0]      r_k, n_k;
    logic signed [31:0] r_key, n_key;
    logic               r_done, n_done;
    logic [1:0]         r_status, n_status;
    logic [4:0]         r_pos, n_pos;
    logic [4:0]         r_len, n_len;
    logic               wr_en;
    logic               accept;
    logic [CW-1:0]      k_inc;

    assign accept = start && (r_state == sfq_pkg::S_IDLE);
    assign k_inc  = r_k + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_ridx   = r_ridx;
        n_k      = r_k;
        n_key    = r_key;
        n_done   = 1'b0;
        n_status = r_status;
        n_pos    = r_pos;
        n_len    = r_len;
        wr_en    = 1'b0;
        unique case (r_state)
            sfq_pkg::S_IDLE: begin
                if (accept) begin
                    n_done   = 1'b1;
                    n_status = sfq_pkg::ST_OK;
                    n_pos    = '0;
                    n_len    = low5(r_count);
                    case (i_kind)
                        sfq_pkg::KIND_PUSH: begin
                            if (r_count == FULL_CNT) begin
                                n_status = sfq_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_tail  = ring_next(r_tail);
                                n_count = r_count + CW'(1);
                                n_len   = low5(n_count);
                            end
                        end
                        sfq_pkg::KIND_POP: begin
                            if (r_count == '0) begin
                                n_status = sfq_pkg::ST_EMPTY;
                            end else begin
                                n_head  = ring_next(r_head);
                                n_count = r_count - CW'(1);
                                n_len   = low5(n_count);
                            end
                        end
                        sfq_pkg::KIND_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = sfq_pkg::ST_EMPTY;
                            end else begin
                                n_done  = 1'b0;
                                n_key   = i_value;
                                n_ridx  = r_head;
                                n_k     = '0;
                                n_state = sfq_pkg::S_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sfq_pkg::S_FETCH: begin
                n_ridx  = ring_next(r_ridx);
                n_state = sfq_pkg::S_CMP;
            end
            sfq_pkg::S_CMP: begin
                n_len = low5(r_count);
                if (r_rdata == r_key) begin
                    n_done   = 1'b1;
                    n_status = sfq_pkg::ST_OK;
                    n_pos    = low5(k_inc);
                    n_state  = sfq_pkg::S_IDLE;
                end else if (k_inc == r_count) begin
                    n_done   = 1'b1;
                    n_status = sfq_pkg::ST_MISS;
                    n_pos    = '0;
                    n_state  = sfq_pkg::S_IDLE;
                end else begin
                    n_k    = k_inc;
                    n_ridx = ring_next(r_ridx);
                end
            end
            default: begin
                n_state = sfq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfq_pkg::S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx   <= n_ridx;
        r_k      <= n_k;
        r_key    <= n_key;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_len    <= n_len;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= i_value;
        end
        r_rdata <= r_mem[r_ridx];
    end

    assign busy       = (r_state != sfq_pkg::S_IDLE);
    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_position = r_pos;
    assign o_length   = r_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue length exceeds its depth");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_kind != sfq_pkg::KIND_SEARCH || r_count == '0)
        |=> o_done && !busy)
        else $error("short request did not report in the next cycle");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sfq_pkg::S_CMP |-> r_k < r_count)
        else $error("search scanned past the held entries");

    a_count_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sfq_pkg::S_CMP |-> $stable(r_count))
        else $error("queue length changed during a search");

    a_position_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_position != '0 |-> o_status == sfq_pkg::ST_OK)
        else $error("position reported without a match");

endmodule

// ----- verif/testbench.sv -----
module testbench;

    localparam int DEPTH = 16;
    localparam int RANDOM_REQUESTS = 1950;
    localparam int CALM_TAIL = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] position;
        logic [4:0] length;
    } t_sfq_result;

    // Mirror of the queue contents, updated in the order requests are accepted.
    class queue_mirror;
        logic [31:0] words [DEPTH];
        int unsigned head;
        int unsigned tail;
        int unsigned held;
        t_sfq_result expected_results [$];
        int mismatch_count;

        function new();
            head = 0;
            tail = 0;
            held = 0;
            mismatch_count = 0;
        endfunction

        function logic [31:0] held_word(int unsigned offset);
            return words[(head + offset) % DEPTH];
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void note_request(logic [1:0] kind, logic [31:0] word);
            t_sfq_result res;
            int unsigned idx;
            res.status = sfq_pkg::ST_OK;
            res.position = '0;
            if (kind == sfq_pkg::KIND_PUSH) begin
                if (held >= DEPTH) begin
                    res.status = sfq_pkg::ST_FULL;
                end else begin
                    words[tail] = word;
                    tail = (tail + 1) % DEPTH;
                    held++;
                end
            end else if (kind == sfq_pkg::KIND_POP) begin
                if (held == 0) begin
                    res.status = sfq_pkg::ST_EMPTY;
                end else begin
                    head = (head + 1) % DEPTH;
                    held--;
                end
            end else if (kind == sfq_pkg::KIND_SEARCH) begin
                if (held == 0) begin
                    res.status = sfq_pkg::ST_EMPTY;
                end else begin
                    res.status = sfq_pkg::ST_MISS;
                    idx = head;
                    for (int k = 0; k < held; k++) begin
                        if (words[idx] == word) begin
                            res.status = sfq_pkg::ST_OK;
                            res.position = 5'(k + 1);
                            break;
                        end
                        idx = (idx + 1) % DEPTH;
                    end
                end
            end
            res.length = 5'(held);
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [1:0] status, logic [4:0] position, logic [4:0] length);
            t_sfq_result want;
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: status %0d, position %0d, length %0d",
                         $time, status, position, length);
                mismatch_count++;
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status) begin
                $display("%0t status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
                mismatch_count++;
            end
            if (position !== want.position) begin
                $display("%0t position mismatch: expected %0d, actual %0d",
                         $time, want.position, position);
                mismatch_count++;
            end
            if (length !== want.length) begin
                $display("%0t length mismatch: expected %0d, actual %0d",
                         $time, want.length, length);
                mismatch_count++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_kind;
    logic signed [31:0] i_value;
    logic               o_done;
    logic [1:0]         o_status;
    logic [4:0]         o_position;
    logic [4:0]         o_length;

    queue_mirror board = new();
    int quiet_cycles;

    searchable_fifo_queue_top #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_kind    (i_kind),
        .i_value   (i_value),
        .o_done    (o_done),
        .o_status  (o_status),
        .o_position(o_position),
        .o_length  (o_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            board.note_request(i_kind, i_value);
        end
        if (i_rst_n && o_done) begin
            board.check_result(o_status, o_position, o_length);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic send_request(logic [1:0] kind, logic [31:0] word);
        @(negedge i_clk);
        start <= 1'b1;
        i_kind <= kind;
        i_value <= word;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause_requests(int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        i_kind <= 2'($urandom_range(3));
        i_value <= $urandom;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4, 5: return 32'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int push_bias;
        bit idling_on;
        int roll;
        logic [1:0] kind;
        logic [31:0] word;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_kind = sfq_pkg::KIND_PUSH;
        i_value = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(sfq_pkg::KIND_SEARCH, 32'h0000_0001);
        send_request(sfq_pkg::KIND_POP, 32'h0000_0000);
        send_request(KIND_UNUSED, 32'hFFFF_FFFF);
        send_request(sfq_pkg::KIND_PUSH, 32'h8000_0000);
        send_request(sfq_pkg::KIND_PUSH, 32'h7FFF_FFFF);
        send_request(sfq_pkg::KIND_PUSH, 32'h0000_0000);
        send_request(sfq_pkg::KIND_PUSH, 32'hFFFF_FFFF);
        send_request(sfq_pkg::KIND_PUSH, 32'h7FFF_FFFF);
        send_request(sfq_pkg::KIND_SEARCH, 32'h8000_0000);
        send_request(sfq_pkg::KIND_SEARCH, 32'h7FFF_FFFF);
        send_request(sfq_pkg::KIND_SEARCH, 32'hFFFF_FFFF);
        send_request(sfq_pkg::KIND_SEARCH, 32'h0000_3039);
        send_request(KIND_UNUSED, 32'h0000_0000);
        send_request(sfq_pkg::KIND_POP, 32'h0000_0000);
        send_request(sfq_pkg::KIND_POP, 32'h0000_0000);
        send_request(sfq_pkg::KIND_POP, 32'h0000_0000);
        send_request(sfq_pkg::KIND_POP, 32'h0000_0000);
        send_request(sfq_pkg::KIND_POP, 32'h0000_0000);
        send_request(sfq_pkg::KIND_POP, 32'h0000_0000);
        send_request(sfq_pkg::KIND_SEARCH, 32'h0000_0000);

        push_bias = 50;
        idling_on = 1'b0;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % 60 == 0) begin
                case ($urandom_range(2))
                    0: push_bias = 85;
                    1: push_bias = 50;
                    default: push_bias = 15;
                endcase
                idling_on = 1'($urandom_range(1));
            end
            if (idling_on && i < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(99) < 30) begin
                pause_requests($urandom_range(1, 10));
            end
            roll = $urandom_range(99);
            if (roll < 3) begin
                kind = KIND_UNUSED;
                word = $urandom;
            end else if (roll < 33) begin
                kind = sfq_pkg::KIND_SEARCH;
                if (board.held > 0 && $urandom_range(99) < 70) begin
                    word = board.held_word($urandom_range(board.held - 1));
                end else begin
                    word = pick_word();
                end
            end else if ($urandom_range(99) < push_bias) begin
                kind = sfq_pkg::KIND_PUSH;
                word = pick_word();
            end else begin
                kind = sfq_pkg::KIND_POP;
                word = $urandom;
            end
            send_request(kind, word);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);

        if (board.mismatch_count == 0 && board.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
sv/sfq_pkg.sv
sv/searchable_fifo_queue_top.sv
verif/testbench.sv
